// ----- sv/assert_macros.svh -----
// Assertion macros included by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// ----- sv/bvlsc_pkg.sv -----
// Types and constants for the ball valve limit switch controller
package bvlsc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 32;
  localparam int WINDOW_W       = 32;
  localparam int PCT_W          = 7;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_SHUT = 7'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SWITCH_ABSENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT_TIMEOUT    = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_OPEN    = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_PERCENT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_IDLE  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_UNKNOWN  = 3'd0,
    ST_OPENING  = 3'd1,
    ST_OPENED   = 3'd2,
    ST_CLOSING  = 3'd3,
    ST_CLOSED   = 3'd4,
    ST_FLOATING = 3'd5,
    ST_FAULTED  = 3'd6
  } valve_t;

endpackage

// ----- sv/ball_valve_limit_switch_controller.sv -----
// Ball valve controller: command register, state update and result register
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  command  | cmd_valid / cmd_stall  | command, now_ms, bypass_window_in, ...
//  result   | res_valid / res_stall  | servo_action, servo_percent, status
//  config   | cfg_write              | cfg_index, cfg_data
//
// One transaction a cycle while the result side does not stall; a command passes
// through the command register, then the result register and valve state.
// The state update is one pass of logic with two time subtract-compares.
// cmd_stall rises only while the result register is full and stalled.
// Synchronous reset clears the valve state and both configuration registers.
module ball_valve_limit_switch_controller
  import bvlsc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic [1:0]            command,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic [WINDOW_W-1:0]   bypass_window_in,
  input  logic [7:0]            target_percent,
  input  logic                  open_switch,
  input  logic                  close_switch,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [1:0]            servo_action,
  output logic [PCT_W-1:0]      servo_percent,
  output logic [2:0]            valve_state,
  output logic                  travelling,
  output logic                  open_limit_flag,
  output logic                  shut_limit_flag,
  output logic                  fault_both,
  output logic [PCT_W-1:0]      commanded_percent,
  output logic [TIME_WIDTH-1:0] movement_end_ms
);

`include "assert_macros.svh"

  localparam int CMP_W = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;

  // configuration
  logic                open_switch_absent;
  logic [WINDOW_W-1:0] transit_timeout_ms;

  // command register
  logic                  held;
  cmd_t                  cmd_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [WINDOW_W-1:0]   bypass_q;
  logic [7:0]            pct_q;
  logic                  osw_q;
  logic                  csw_q;

  // valve state, which is also the status half of the result register
  valve_t                valve_mode, valve_mode_next;
  logic                  moving_flag, moving_flag_next;
  logic                  open_seen, open_seen_next;
  logic                  closed_seen, closed_seen_next;
  logic                  both_fault, both_fault_next;
  logic [PCT_W-1:0]      set_percent, set_percent_next;
  logic [TIME_WIDTH-1:0] move_start_ms, move_start_ms_next;
  logic [TIME_WIDTH-1:0] move_end_ms, move_end_ms_next;
  logic [WINDOW_W-1:0]   bypass_window, bypass_window_next;

  // action half of the result register
  act_t             act, act_next;
  logic [PCT_W-1:0] act_pct, act_pct_next;

  logic out_free;
  logic advance;

  logic                  open_active;
  logic                  shut_active;
  logic                  both_hit;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  timed_out;
  logic                  window_gone;
  logic                  arrived;
  logic                  redundant_open;
  logic                  redundant_close;
  logic [PCT_W-1:0]      pct_clamped;
  logic                  in_motion_mode;

  assign out_free  = !res_valid || !res_stall;
  assign advance   = held && out_free;
  assign cmd_stall = held && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_switch_absent <= 1'b0;
      transit_timeout_ms <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OPEN_SWITCH_ABSENT: open_switch_absent <= cfg_data[0];
        CFG_TRANSIT_TIMEOUT:    transit_timeout_ms <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q    <= cmd_t'(command);
      now_q    <= now_ms;
      bypass_q <= bypass_window_in;
      pct_q    <= target_percent;
      osw_q    <= open_switch;
      csw_q    <= close_switch;
    end
  end

  // shared conditions
  assign open_active = !open_switch_absent && osw_q;
  assign shut_active = csw_q;
  assign both_hit    = open_active && shut_active;
  assign elapsed     = now_q - move_start_ms;
  assign timed_out   = CMP_W'(elapsed) >= CMP_W'(transit_timeout_ms);
  assign window_gone = CMP_W'(elapsed) >= CMP_W'(bypass_window);
  assign arrived     = (valve_mode == ST_OPENING) ? open_active : shut_active;
  assign pct_clamped = (pct_q > 8'd100) ? PCT_FULL : pct_q[PCT_W-1:0];

  assign redundant_open  = (bypass_q == '0) && (valve_mode inside {ST_OPENED, ST_OPENING});
  assign redundant_close = (bypass_q == '0) && (valve_mode inside {ST_CLOSED, ST_CLOSING});
  assign in_motion_mode  = valve_mode inside {ST_OPENING, ST_CLOSING, ST_FLOATING};

  // next valve state
  always_comb begin
    valve_mode_next    = valve_mode;
    moving_flag_next   = moving_flag;
    open_seen_next     = open_seen;
    closed_seen_next   = closed_seen;
    both_fault_next    = both_fault;
    set_percent_next   = set_percent;
    move_start_ms_next = move_start_ms;
    move_end_ms_next   = move_end_ms;
    bypass_window_next = bypass_window;
    case (cmd_q)
      CMD_TICK: begin
        open_seen_next   = open_active;
        closed_seen_next = shut_active;
        both_fault_next  = both_hit;
        if (both_hit) begin
          moving_flag_next = 1'b0;
          valve_mode_next  = ST_FAULTED;
        end else begin
          case (valve_mode)
            ST_OPENING, ST_CLOSING: begin
              if (arrived) begin
                valve_mode_next  = (valve_mode == ST_OPENING) ? ST_OPENED : ST_CLOSED;
                moving_flag_next = 1'b0;
                move_end_ms_next = now_q;
              end else if (timed_out && window_gone) begin
                valve_mode_next  = ST_FAULTED;
                moving_flag_next = 1'b0;
                move_end_ms_next = now_q;
              end
            end
            ST_OPENED: begin
              if (!open_active) valve_mode_next = ST_FLOATING;
            end
            ST_CLOSED: begin
              if (!shut_active) valve_mode_next = ST_FLOATING;
            end
            ST_FLOATING: begin
              if (open_active) begin
                valve_mode_next  = ST_OPENED;
                moving_flag_next = 1'b0;
              end else if (shut_active) begin
                valve_mode_next  = ST_CLOSED;
                moving_flag_next = 1'b0;
              end else if (moving_flag && timed_out) begin
                moving_flag_next = 1'b0;
              end
            end
            default: begin
              // unknown or faulted: adopt whichever limit is showing
              if (open_active) valve_mode_next = ST_OPENED;
              else if (shut_active) valve_mode_next = ST_CLOSED;
            end
          endcase
        end
      end
      CMD_OPEN: begin
        if (open_switch_absent) begin
          // no open switch: behave as a full-travel percent move
          bypass_window_next = '0;
          set_percent_next   = PCT_FULL;
          valve_mode_next    = ST_FLOATING;
          moving_flag_next   = 1'b1;
          move_start_ms_next = now_q;
        end else begin
          bypass_window_next = bypass_q;
          set_percent_next   = PCT_FULL;
          if (!redundant_open) begin
            valve_mode_next    = ST_OPENING;
            moving_flag_next   = 1'b1;
            move_start_ms_next = now_q;
          end
        end
      end
      CMD_CLOSE: begin
        bypass_window_next = bypass_q;
        set_percent_next   = PCT_SHUT;
        if (!redundant_close) begin
          valve_mode_next    = ST_CLOSING;
          moving_flag_next   = 1'b1;
          move_start_ms_next = now_q;
        end
      end
      default: begin
        bypass_window_next = '0;
        set_percent_next   = pct_clamped;
        valve_mode_next    = ST_FLOATING;
        moving_flag_next   = 1'b1;
        move_start_ms_next = now_q;
      end
    endcase
  end

  // servo action
  always_comb begin
    act_next     = ACT_NONE;
    act_pct_next = '0;
    case (cmd_q)
      CMD_TICK: begin
        if (both_hit) begin
          act_next = ACT_IDLE;
        end else begin
          case (valve_mode)
            ST_OPENING, ST_CLOSING: begin
              if (arrived || (timed_out && window_gone)) act_next = ACT_IDLE;
            end
            ST_FLOATING: begin
              if (open_active || shut_active || (moving_flag && timed_out)) begin
                act_next = ACT_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_OPEN: begin
        if (open_switch_absent || !redundant_open) begin
          act_next     = ACT_DRIVE;
          act_pct_next = PCT_FULL;
        end
      end
      CMD_CLOSE: begin
        if (!redundant_close) begin
          act_next     = ACT_DRIVE;
          act_pct_next = PCT_SHUT;
        end
      end
      default: begin
        act_next     = ACT_DRIVE;
        act_pct_next = pct_clamped;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      act           <= ACT_NONE;
      act_pct       <= '0;
      valve_mode    <= ST_UNKNOWN;
      moving_flag   <= 1'b0;
      open_seen     <= 1'b0;
      closed_seen   <= 1'b0;
      both_fault    <= 1'b0;
      set_percent   <= '0;
      move_start_ms <= '0;
      move_end_ms   <= '0;
      bypass_window <= '0;
    end else begin
      if (advance) begin
        res_valid     <= 1'b1;
        act           <= act_next;
        act_pct       <= act_pct_next;
        valve_mode    <= valve_mode_next;
        moving_flag   <= moving_flag_next;
        open_seen     <= open_seen_next;
        closed_seen   <= closed_seen_next;
        both_fault    <= both_fault_next;
        set_percent   <= set_percent_next;
        move_start_ms <= move_start_ms_next;
        move_end_ms   <= move_end_ms_next;
        bypass_window <= bypass_window_next;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign servo_action      = act;
  assign servo_percent     = act_pct;
  assign valve_state       = valve_mode;
  assign travelling        = moving_flag;
  assign open_limit_flag   = open_seen;
  assign shut_limit_flag   = closed_seen;
  assign fault_both        = both_fault;
  assign commanded_percent = set_percent;
  assign movement_end_ms   = move_end_ms;

  `ASSERT_IMPLIES(a_drive_moves, res_valid && act == ACT_DRIVE, moving_flag, "drive at rest")
  `ASSERT_IMPLIES(a_idle_stops, res_valid && act == ACT_IDLE, !moving_flag, "idle while moving")
  `ASSERT_IMPLIES(a_moving_mode, moving_flag, in_motion_mode, "transition flag in a resting mode")
  `ASSERT_ALWAYS(a_stall_cause, !cmd_stall || (res_valid && res_stall), "stall without result stall")

endmodule

// ----- dv/bvlsc_status_check.sv -----
`timescale 1ns / 1ps
// Valve status checker: predicts each result of the controller and compares it
module bvlsc_status_check
  import bvlsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  logic [1:0]            command,
  input  logic [31:0]           now_ms,
  input  logic [WINDOW_W-1:0]   bypass_window_in,
  input  logic [7:0]            target_percent,
  input  logic                  open_switch,
  input  logic                  close_switch,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  logic [1:0]            servo_action,
  input  logic [PCT_W-1:0]      servo_percent,
  input  logic [2:0]            valve_state,
  input  logic                  travelling,
  input  logic                  open_limit_flag,
  input  logic                  shut_limit_flag,
  input  logic                  fault_both,
  input  logic [PCT_W-1:0]      commanded_percent,
  input  logic [31:0]           movement_end_ms,
  output int                    mismatch_count,
  output int                    results_due
);

  typedef struct {
    act_t             action;
    logic [PCT_W-1:0] drive_pct;
    valve_t           mode;
    logic             moving;
    logic             open_hi;
    logic             closed_hi;
    logic             both_hi;
    logic [PCT_W-1:0] cmd_pct;
    logic [31:0]      end_ms;
  } valve_status_t;

  valve_status_t status_due[$];

  // controller copy
  logic             sw_absent;
  logic [31:0]      timeout_ms;
  valve_t           mode;
  logic             moving;
  logic             open_seen;
  logic             closed_seen;
  logic             both_flt;
  logic [PCT_W-1:0] cmd_pct;
  logic [31:0]      start_ms;
  logic [31:0]      end_ms;
  logic [31:0]      window;

  initial mismatch_count = 0;
  initial results_due = 0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %0s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%0s got %0h want %0h", name, got, want));
  endtask

  function automatic void float_to(logic [PCT_W-1:0] pct, logic [31:0] now,
                                   inout valve_status_t s);
    window   = '0;
    cmd_pct  = pct;
    mode     = ST_FLOATING;
    moving   = 1'b1;
    start_ms = now;
    s.action    = ACT_DRIVE;
    s.drive_pct = pct;
  endfunction

  function automatic void head_for(valve_t target, valve_t hold, logic [PCT_W-1:0] pct,
                                   logic [31:0] win, logic [31:0] now,
                                   inout valve_status_t s);
    window  = win;
    cmd_pct = pct;
    // redundant request: servo untouched
    if (win == 0 && (mode == hold || mode == target)) return;
    mode     = target;
    moving   = 1'b1;
    start_ms = now;
    s.action    = ACT_DRIVE;
    s.drive_pct = pct;
  endfunction

  function automatic valve_status_t next_valve_status(cmd_t c, logic [31:0] now,
                                                      logic [31:0] win, logic [7:0] req,
                                                      logic osw, logic csw);
    valve_status_t s;
    logic          open_active;
    logic          shut_active;
    logic          timed_out;
    logic [31:0]   elapsed;
    s.action    = ACT_NONE;
    s.drive_pct = PCT_SHUT;
    case (c)
      CMD_TICK: begin
        open_active = !sw_absent && osw;
        shut_active = csw;
        elapsed     = now - start_ms;
        timed_out   = elapsed >= timeout_ms;
        open_seen   = open_active;
        closed_seen = shut_active;
        if (open_active && shut_active) begin
          both_flt = 1'b1;
          moving   = 1'b0;
          mode     = ST_FAULTED;
          s.action = ACT_IDLE;
        end else begin
          both_flt = 1'b0;
          case (mode)
            ST_OPENING, ST_CLOSING: begin
              if ((mode == ST_OPENING) ? open_active : shut_active) begin
                mode     = (mode == ST_OPENING) ? ST_OPENED : ST_CLOSED;
                moving   = 1'b0;
                end_ms   = now;
                s.action = ACT_IDLE;
              end else if (timed_out && elapsed >= window) begin
                mode     = ST_FAULTED;
                moving   = 1'b0;
                end_ms   = now;
                s.action = ACT_IDLE;
              end
            end
            ST_OPENED: if (!open_active) mode = ST_FLOATING;
            ST_CLOSED: if (!shut_active) mode = ST_FLOATING;
            ST_FLOATING: begin
              if (open_active) begin
                mode     = ST_OPENED;
                moving   = 1'b0;
                s.action = ACT_IDLE;
              end else if (shut_active) begin
                mode     = ST_CLOSED;
                moving   = 1'b0;
                s.action = ACT_IDLE;
              end else if (moving && timed_out) begin
                moving   = 1'b0;
                s.action = ACT_IDLE;
              end
            end
            default: begin
              if (open_active) mode = ST_OPENED;
              else if (shut_active) mode = ST_CLOSED;
            end
          endcase
        end
      end
      CMD_OPEN: begin
        if (sw_absent) float_to(PCT_FULL, now, s);
        else head_for(ST_OPENING, ST_OPENED, PCT_FULL, win, now, s);
      end
      CMD_CLOSE: head_for(ST_CLOSING, ST_CLOSED, PCT_SHUT, win, now, s);
      default: float_to((req > 8'd100) ? PCT_FULL : req[PCT_W-1:0], now, s);
    endcase
    s.mode      = mode;
    s.moving    = moving;
    s.open_hi   = open_seen;
    s.closed_hi = closed_seen;
    s.both_hi   = both_flt;
    s.cmd_pct   = cmd_pct;
    s.end_ms    = end_ms;
    return s;
  endfunction

  always @(posedge clk) begin
    valve_status_t want;
    if (rst) begin
      sw_absent   = 1'b0;
      timeout_ms  = '0;
      mode        = ST_UNKNOWN;
      moving      = 1'b0;
      open_seen   = 1'b0;
      closed_seen = 1'b0;
      both_flt    = 1'b0;
      cmd_pct     = '0;
      start_ms    = '0;
      end_ms      = '0;
      window      = '0;
      status_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (status_due.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = status_due.pop_front();
          check_field("servo_action", 32'(servo_action), 32'(want.action));
          check_field("servo_percent", 32'(servo_percent), 32'(want.drive_pct));
          check_field("valve_state", 32'(valve_state), 32'(want.mode));
          check_field("travelling", 32'(travelling), 32'(want.moving));
          check_field("open_limit_flag", 32'(open_limit_flag), 32'(want.open_hi));
          check_field("shut_limit_flag", 32'(shut_limit_flag), 32'(want.closed_hi));
          check_field("fault_both", 32'(fault_both), 32'(want.both_hi));
          check_field("commanded_percent", 32'(commanded_percent), 32'(want.cmd_pct));
          check_field("movement_end_ms", movement_end_ms, want.end_ms);
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_OPEN_SWITCH_ABSENT) sw_absent = cfg_data[0];
        else if (cfg_index == CFG_TRANSIT_TIMEOUT) timeout_ms = cfg_data;
      end
      if (cmd_valid && !cmd_stall)
        status_due.push_back(next_valve_status(cmd_t'(command), now_ms, bypass_window_in,
                                               target_percent, open_switch, close_switch));
    end
    results_due <= status_due.size();
  end

endmodule

// ----- dv/tb_ball_valve_limit_switch_controller.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, configuration, command and stall stimulus, and the verdict
module tb_ball_valve_limit_switch_controller;
  import bvlsc_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 225;
  localparam int LONG_HOLD    = 120;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst               = 1'b1;
  logic                  cfg_write         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;
  logic                  cmd_valid         = 1'b0;
  logic                  cmd_stall;
  logic [1:0]            command           = CMD_TICK;
  logic [31:0]           now_ms            = '0;
  logic [WINDOW_W-1:0]   bypass_window_in  = '0;
  logic [7:0]            target_percent    = '0;
  logic                  open_switch       = 1'b0;
  logic                  close_switch      = 1'b0;
  logic                  res_valid;
  logic                  res_stall         = 1'b0;
  logic [1:0]            servo_action;
  logic [PCT_W-1:0]      servo_percent;
  logic [2:0]            valve_state;
  logic                  travelling;
  logic                  open_limit_flag;
  logic                  shut_limit_flag;
  logic                  fault_both;
  logic [PCT_W-1:0]      commanded_percent;
  logic [31:0]           movement_end_ms;

  int          mismatch_count;
  int          results_due;
  int          sent_count = 0;
  int          burst_left = 0;
  bit          gappy      = 1'b0;
  logic [31:0] clock_ms;
  logic [7:0]  goal_pct   = 8'd0;

  ball_valve_limit_switch_controller DUT (.*);

  bvlsc_status_check status_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: stall pattern in segments, plus long hold-offs mid-run
  initial begin
    int seg_left;
    int seg_mode;
    int holds_done;
    seg_left   = 0;
    seg_mode   = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < 2 && sent_count >= (holds_done + 1) * 500) begin
        holds_done++;
        res_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (seg_mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 9) < 7);
          default: res_stall <= ~res_stall;
        endcase
      end
    end
  end

  task automatic offer_command(cmd_t c, logic [31:0] now, logic [31:0] win,
                               logic [7:0] req, logic osw, logic csw);
    cmd_valid        <= 1'b1;
    command          <= c;
    now_ms           <= now;
    bypass_window_in <= win;
    target_percent   <= req;
    open_switch      <= osw;
    close_switch     <= csw;
    do @(posedge clk); while (cmd_stall);
    sent_count <= sent_count + 1;
  endtask

  task automatic pace();
    if (gappy && burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // sender pauses until every outstanding result is back
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(logic absent, logic [31:0] timeout);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OPEN_SWITCH_ABSENT;
    cfg_data  <= {31'd0, absent};
    @(posedge clk);
    cfg_index <= CFG_TRANSIT_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_command();
    cmd_t        c;
    logic [31:0] win;
    logic [7:0]  req;
    logic        osw;
    logic        csw;
    int          r;
    r = $urandom_range(0, 99);
    c = (r < 50) ? CMD_TICK : (r < 65) ? CMD_OPEN : (r < 80) ? CMD_CLOSE : CMD_PERCENT;
    r = $urandom_range(0, 99);
    if (r < 90) clock_ms += $urandom_range(0, 9);
    else if (r < 98) clock_ms += $urandom_range(10, 200);
    else clock_ms += $urandom;
    r = $urandom_range(0, 99);
    win = (r < 70) ? 32'd0 : (r < 90) ? 32'($urandom_range(1, 60)) : 32'($urandom);
    req = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 100))
                                       : 8'($urandom_range(0, 255));
    // switches follow where the valve was last sent for 45 percent of commands
    r = $urandom_range(0, 99);
    if (r < 45) begin
      osw = (goal_pct == 8'd100);
      csw = (goal_pct == 8'd0);
    end else if (r < 75) begin
      osw = 1'b0;
      csw = 1'b0;
    end else if (r < 92) begin
      osw = 1'($urandom_range(0, 1));
      csw = 1'($urandom_range(0, 1));
    end else begin
      osw = 1'b1;
      csw = 1'b1;
    end
    case (c)
      CMD_OPEN:    goal_pct = 8'd100;
      CMD_CLOSE:   goal_pct = 8'd0;
      CMD_PERCENT: goal_pct = (req > 8'd100) ? 8'd100 : req;
      default:     ;
    endcase
    offer_command(c, clock_ms, win, req, osw, csw);
    pace();
  endtask

  initial begin
    logic [31:0] t;
    logic        absent_set[PHASES];
    logic [31:0] timeout_set[PHASES];
    absent_set  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    timeout_set = '{32'd0, 32'd25, 32'hFFFF_FFFF, 32'd40, 32'd12, 32'($urandom)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_settings(1'b0, 32'd10);
    t = 32'hFFFF_FFF0;
    offer_command(CMD_TICK, t, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
    offer_command(CMD_TICK, t + 1, 32'd0, 8'd0, 1'b1, 1'b0);
    offer_command(CMD_OPEN, t + 2, 32'd0, 8'd0, 1'b1, 1'b1);
    offer_command(CMD_TICK, t + 3, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_CLOSE, t + 4, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_CLOSE, t + 5, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, t + 8, 32'd0, 8'd0, 1'b0, 1'b0);
    // time wraps here; arrival wins over the elapsed timeout
    offer_command(CMD_TICK, 32'h2, 32'd0, 8'd0, 1'b0, 1'b1);
    offer_command(CMD_OPEN, 32'h3, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h40, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h41, 32'd0, 8'd0, 1'b1, 1'b1);
    offer_command(CMD_TICK, 32'h42, 32'd0, 8'd0, 1'b1, 1'b1);
    offer_command(CMD_TICK, 32'h43, 32'd0, 8'd0, 1'b0, 1'b1);
    offer_command(CMD_PERCENT, 32'h44, 32'd0, 8'hFF, 1'b0, 1'b0);
    offer_command(CMD_PERCENT, 32'h45, 32'd0, 8'd101, 1'b0, 1'b0);
    offer_command(CMD_PERCENT, 32'h46, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_PERCENT, 32'h47, 32'd0, 8'd100, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h48, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h60, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_OPEN, 32'h61, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h70, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_CLOSE, 32'h71, 32'd5, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h7A, 32'd0, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h7B, 32'd0, 8'd0, 1'b0, 1'b1);
    settle();
    // open switch absent: open becomes a full-travel float, switch ignored
    write_settings(1'b1, 32'd0);
    offer_command(CMD_OPEN, 32'h80, 32'd7, 8'd0, 1'b0, 1'b0);
    offer_command(CMD_TICK, 32'h81, 32'd0, 8'd0, 1'b1, 1'b0);
    offer_command(CMD_TICK, 32'h82, 32'd0, 8'd0, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_settings(absent_set[p], timeout_set[p]);
      gappy      = (p % 3 != 2);
      burst_left = 0;
      clock_ms   = (p == 4) ? 32'hFFFF_FF00 : 32'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) random_command();
      settle();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
